// ===== rtl/bcrf_pkg.sv =====
`default_nettype none
package bcrf_pkg;

    localparam int unsigned SLOT_W    = 6;
    localparam int unsigned NUM_SLOTS = 37;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned RN_W      = 5;
    localparam int unsigned MODE_W    = 5;

    localparam logic [SLOT_W-1:0]  STATUS_SLOT  = 6'd16;
    localparam logic [WORD_W-1:0]  STATUS_RESET = 32'h0000_00D3;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLAG  = 2'd2;
    localparam logic [1:0] OP_MODE  = 2'd3;

    // logical register numbers with a special meaning
    localparam logic [RN_W-1:0] RN_STATUS = 5'd16;
    localparam logic [RN_W-1:0] RN_SAVED  = 5'd17;

    // processor mode codes
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
    localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;

    // exception bank numbers
    localparam logic [2:0] BANK_FIQ  = 3'd0;
    localparam logic [2:0] BANK_SVC  = 3'd1;
    localparam logic [2:0] BANK_ABT  = 3'd2;
    localparam logic [2:0] BANK_IRQ  = 3'd3;
    localparam logic [2:0] BANK_UND  = 3'd4;
    localparam logic [2:0] BANK_NONE = 3'd7;

    typedef struct packed {
        logic cap;      // latch the incoming item
        logic exec;     // perform the access
        logic load_out; // load the output register
    } bcrf_cmd_t;

    typedef struct packed {
        logic              hit;
        logic              bad;
        logic [SLOT_W-1:0] slot;
    } bcrf_map_t;

    function automatic logic [4:0] flag_bit(input logic [2:0] fsel);
        logic [4:0] b;
        case (fsel)
            3'd0:    b = 5'd31;
            3'd1:    b = 5'd30;
            3'd2:    b = 5'd29;
            3'd3:    b = 5'd28;
            3'd4:    b = 5'd27;
            3'd5:    b = 5'd7;
            3'd6:    b = 5'd6;
            default: b = 5'd5;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] exception_bank(input logic [MODE_W-1:0] m);
        logic [2:0] b;
        case (m)
            MODE_FIQ: b = BANK_FIQ;
            MODE_SVC: b = BANK_SVC;
            MODE_ABT: b = BANK_ABT;
            MODE_IRQ: b = BANK_IRQ;
            MODE_UND: b = BANK_UND;
            default:  b = BANK_NONE;
        endcase
        return b;
    endfunction

    function automatic bcrf_map_t map_slot(input logic [RN_W-1:0] rn,
                                           input logic [MODE_W-1:0] m);
        bcrf_map_t  r;
        logic [2:0] b;
        logic [SLOT_W-1:0] rn6;
        b   = exception_bank(m);
        rn6 = {1'b0, rn};
        r.hit  = 1'b1;
        r.bad  = 1'b0;
        r.slot = rn6;
        if (rn <= 5'd7 || rn == 5'd15 || rn == RN_STATUS) begin
            r.slot = rn6;
        end
        else if (rn <= 5'd12) begin
            r.slot = (b == BANK_FIQ) ? rn6 + 6'd9 : rn6;
        end
        else if (rn <= 5'd14) begin
            r.slot = (b == BANK_NONE) ? rn6
                   : 6'd22 + {2'b00, b, 1'b0} + (rn6 - 6'd13);
        end
        else if (rn == RN_SAVED) begin
            if (b == BANK_NONE) begin
                r.hit  = 1'b0;
                r.bad  = 1'b1;
                r.slot = '0;
            end
            else begin
                r.slot = 6'd32 + {3'b000, b};
            end
        end
        else begin
            r.hit  = 1'b0;
            r.slot = '0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bcrf_ctrl.sv =====
`default_nettype none
module bcrf_ctrl
    import bcrf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output bcrf_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.cap      = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bcrf_datapath.sv =====
`default_nettype none
module bcrf_datapath
    import bcrf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcrf_cmd_t         cmd,
    input  wire logic [1:0]        in_mode,
    input  wire logic [RN_W-1:0]   in_register_number,
    input  wire logic [2:0]        in_flag_select,
    input  wire logic              in_bit_value,
    input  wire logic [WORD_W-1:0] in_write_data,
    output logic [WORD_W-1:0]      read_data,
    output logic [SLOT_W-1:0]      bank_slot,
    output logic                   bad_access,
    output logic [MODE_W-1:0]      current_mode_bits
);

    localparam logic [1:0] SRC_ZERO   = 2'd0;
    localparam logic [1:0] SRC_STATUS = 2'd1;
    localparam logic [1:0] SRC_WDATA  = 2'd2;
    localparam logic [1:0] SRC_MEM    = 2'd3;

    logic [WORD_W-1:0] mem [NUM_SLOTS];

    logic [1:0]        op_reg;
    logic [RN_W-1:0]   rn_reg;
    logic [2:0]        fsel_reg;
    logic              bit_reg;
    logic [WORD_W-1:0] wdata_reg;

    logic [WORD_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0] mem_q_reg;
    logic [1:0]        src_reg, src_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              bad_reg, bad_next;
    logic              mem_we;

    logic [WORD_W-1:0] read_data_reg;
    logic [SLOT_W-1:0] bank_slot_reg;
    logic              bad_access_reg;
    logic [MODE_W-1:0] mode_bits_reg;

    bcrf_map_t         map;
    logic [WORD_W-1:0] flag_mask;
    logic [WORD_W-1:0] sel_data;

    assign map       = map_slot(rn_reg, status_reg[MODE_W-1:0]);
    assign flag_mask = {{(WORD_W-1){1'b0}}, 1'b1} << flag_bit(fsel_reg);

    always_comb
    begin
        status_next = status_reg;
        src_next    = SRC_ZERO;
        slot_next   = '0;
        bad_next    = 1'b0;
        mem_we      = 1'b0;
        case (op_reg)
            OP_FLAG:
            begin
                status_next = bit_reg ? (status_reg | flag_mask)
                                      : (status_reg & ~flag_mask);
                src_next    = SRC_STATUS;
                slot_next   = STATUS_SLOT;
            end
            OP_MODE:
            begin
                status_next = {status_reg[WORD_W-1:MODE_W], wdata_reg[MODE_W-1:0]};
                src_next    = SRC_STATUS;
                slot_next   = STATUS_SLOT;
            end
            default:
            begin
                bad_next = map.bad;
                if (map.hit)
                begin
                    slot_next = map.slot;
                    if (map.slot == STATUS_SLOT)
                    begin
                        src_next = SRC_STATUS;
                        if (op_reg == OP_WRITE)
                            status_next = wdata_reg;
                    end
                    else if (op_reg == OP_WRITE)
                    begin
                        src_next = SRC_WDATA;
                        mem_we   = 1'b1;
                    end
                    else
                    begin
                        src_next = SRC_MEM;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        case (src_reg)
            SRC_STATUS: sel_data = status_reg;
            SRC_WDATA:  sel_data = wdata_reg;
            SRC_MEM:    sel_data = mem_q_reg;
            default:    sel_data = '0;
        endcase
    end

    // banked slot storage, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (mem_we)
                mem[slot_next] <= wdata_reg;
            mem_q_reg <= mem[slot_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg    <= in_mode;
            rn_reg    <= in_register_number;
            fsel_reg  <= in_flag_select;
            bit_reg   <= in_bit_value;
            wdata_reg <= in_write_data;
        end
        if (cmd.exec)
        begin
            src_reg  <= src_next;
            slot_reg <= slot_next;
            bad_reg  <= bad_next;
        end
        if (cmd.load_out)
        begin
            read_data_reg  <= sel_data;
            bank_slot_reg  <= slot_reg;
            bad_access_reg <= bad_reg;
            mode_bits_reg  <= status_reg[MODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_reg <= STATUS_RESET;
        else if (cmd.exec)
            status_reg <= status_next;
    end

    assign read_data         = read_data_reg;
    assign bank_slot         = bank_slot_reg;
    assign bad_access        = bad_access_reg;
    assign current_mode_bits = mode_bits_reg;

endmodule
`default_nettype wire

// ===== rtl/banked_cpu_register_file_core.sv =====
`default_nettype none
// channel  | direction | payload
// ---------+-----------+--------------------------------------------------------
// s_axis   | in        | tuser: mode; tdata: register_number, flag_select,
//          |           |   bit_value, write_data
// m_axis   | out       | tuser: bad_access; tdata: read_data, bank_slot,
//          |           |   current_mode_bits
//
// each item passes three steps: capture, access of the slot memory, load of the
// output register; the slot memory has a single port and a registered read
// s_tready is high only while the controller is idle; a result waiting in the
// output register does not stop the next item from being captured
// a stalled output holds the third step until m_tready frees the output register
// reset sets the status word to 0xd3 (supervisor, i and f set); other slots are
// undefined until written
module banked_cpu_register_file_core
    import bcrf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,  // [1:0] mode
    input  wire logic [47:0] s_tdata,  // [4:0] register_number, [7:5] flag_select,
                                       // [8] bit_value, [40:9] write_data, rest zero
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [0:0]       m_tuser,  // [0] bad_access
    output logic [47:0]      m_tdata   // [31:0] read_data, [37:32] bank_slot,
                                       // [42:38] current_mode_bits, rest zero
);

    bcrf_cmd_t         cmd;
    logic [WORD_W-1:0] read_data;
    logic [SLOT_W-1:0] bank_slot;
    logic              bad_access;
    logic [MODE_W-1:0] current_mode_bits;

    // sequencing: idle, access, result
    bcrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // bank mapping, status word, slot memory and output register
    bcrf_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .in_mode            (s_tuser),
        .in_register_number (s_tdata[4:0]),
        .in_flag_select     (s_tdata[7:5]),
        .in_bit_value       (s_tdata[8]),
        .in_write_data      (s_tdata[40:9]),
        .read_data          (read_data),
        .bank_slot          (bank_slot),
        .bad_access         (bad_access),
        .current_mode_bits  (current_mode_bits)
    );

    // pack the result item, zero fill to whole bytes
    assign m_tdata = {5'b00000, current_mode_bits, bank_slot, read_data};
    assign m_tuser = bad_access;

endmodule
`default_nettype wire
